[rtl/hbcc_pkg.sv]
`timescale 1ns / 1ps

package hbcc_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 512;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int ROW_BITS    = 32;
    localparam int BIT_W       = $clog2(ROW_BITS);
    localparam int ROWS        = TABLE_DEPTH / ROW_BITS;
    localparam int ROW_W       = $clog2(ROWS);

    // Field and register widths
    localparam int SIZE_W  = 10;
    localparam int SEL_W   = 2;
    localparam int MODE_W  = 2;
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 16;
    localparam int SUM_W   = 24;
    localparam int ELF_W   = 28;
    localparam int COLL_W  = 32;
    localparam int USED_W  = 10;
    localparam int CFG_W   = 10;
    localparam int CIDX_W  = 1;

    // Divider runs one quotient bit per step over the widest hash
    localparam int DIV_STEPS = ELF_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(30);
    localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(TABLE_DEPTH);

    // Item modes
    localparam logic [MODE_W-1:0] MODE_BYTE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_END   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    // Hash selector codes
    localparam logic [SEL_W-1:0] SEL_LENGTH = 2'd0;
    localparam logic [SEL_W-1:0] SEL_ELF    = 2'd1;

    // Register indexes
    localparam logic [CIDX_W-1:0] REG_TABLE_SIZE  = 1'd0;
    localparam logic [CIDX_W-1:0] REG_HASH_SELECT = 1'd1;

    typedef struct packed {
        logic             take_byte;
        logic             start_div;
        logic             div_step;
        logic             mem_rd;
        logic             commit;
        logic             clr_counts;
        logic             clr_row_en;
        logic [ROW_W-1:0] clr_row;
    } t_cmd;

endpackage

[rtl/hbcc_ctrl.sv]
`timescale 1ns / 1ps

module hbcc_ctrl
    import hbcc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [MODE_W-1:0] i_mode,
    input  logic              i_out_ready,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output t_cmd              o_cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_UPDATE
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic [ROW_W-1:0]  r_row, n_row;
    logic              r_out_valid, n_out_valid;
    logic              in_acc;
    logic              out_free;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign in_acc      = i_in_valid && (r_state == ST_IDLE);
    assign out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_row       = r_row;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.clr_row = r_row;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_row_en = 1'b1;
                n_row = r_row + 1'b1;
                if (r_row == ROW_W'(ROWS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (i_mode)
                        MODE_BYTE: o_cmd.take_byte = 1'b1;
                        MODE_END: begin
                            o_cmd.start_div = 1'b1;
                            n_step  = '0;
                            n_state = ST_DIV;
                        end
                        MODE_CLEAR: begin
                            o_cmd.clr_counts = 1'b1;
                            n_row   = '0;
                            n_state = ST_CLEAR;
                        end
                        default: ;  // unused mode: dropped
                    endcase
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.mem_rd = 1'b1;
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_step      <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_row       <= n_row;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[rtl/hbcc_datapath.sv]
`timescale 1ns / 1ps

module hbcc_datapath
    import hbcc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [BYTE_W-1:0] i_key_byte,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    output logic [IDX_W-1:0]  o_bucket,
    output logic              o_collided,
    output logic [COLL_W-1:0] o_collision_total,
    output logic [USED_W-1:0] o_buckets_used
);

    // Configuration
    logic [SIZE_W-1:0] r_table_size;
    logic [SEL_W-1:0]  r_hash_select;

    // Running hashes of the key in progress
    logic [ELF_W-1:0] r_elf;
    logic [SUM_W-1:0] r_sum;
    logic [LEN_W-1:0] r_len;

    // Divider
    logic [ELF_W-1:0]  r_quo;
    logic [SIZE_W-1:0] r_rem;
    logic [SIZE_W-1:0] r_div;

    // Counts
    logic [COLL_W-1:0] r_coll;
    logic [USED_W-1:0] r_used;

    // Bitmap, one row of ROW_BITS buckets per word
    logic [ROW_BITS-1:0] r_bitmap [ROWS];
    logic [ROW_BITS-1:0] r_rd_data;

    // Output payload
    logic [IDX_W-1:0]  r_bucket;
    logic              r_collided;
    logic [COLL_W-1:0] r_coll_out;
    logic [USED_W-1:0] r_used_out;

    logic [31:0]         elf_sum;
    logic [ELF_W-1:0]    elf_next;
    logic [ELF_W-1:0]    hash_sel;
    logic [SIZE_W-1:0]   eff_size;
    logic [SIZE_W-1:0]   rem_try;
    logic [ROW_W-1:0]    cur_row;
    logic [BIT_W-1:0]    cur_bit;
    logic                hit;
    logic                wr_en;
    logic [ROW_W-1:0]    wr_row;
    logic [ROW_BITS-1:0] wr_data;

    // ELF step: shift in the byte, fold the top nibble into bits 7:4, drop it
    assign elf_sum  = {r_elf, 4'b0} + {24'b0, i_key_byte};
    assign elf_next = elf_sum[ELF_W-1:0] ^ {20'b0, elf_sum[31:28], 4'b0};

    always_comb begin
        case (r_hash_select)
            SEL_LENGTH: hash_sel = {{(ELF_W-LEN_W){1'b0}}, r_len};
            SEL_ELF:    hash_sel = r_elf;
            default:    hash_sel = {{(ELF_W-SUM_W){1'b0}}, r_sum};
        endcase
    end

    always_comb begin
        if (r_table_size == '0) begin
            eff_size = SIZE_W'(1);
        end else if (r_table_size > SIZE_MAX) begin
            eff_size = SIZE_MAX;
        end else begin
            eff_size = r_table_size;
        end
    end

    // Restoring step; remainder stays below the divisor so its top bit is zero
    assign rem_try = {r_rem[SIZE_W-2:0], r_quo[ELF_W-1]};

    assign cur_row = r_rem[IDX_W-1:BIT_W];
    assign cur_bit = r_rem[BIT_W-1:0];
    assign hit     = r_rd_data[cur_bit];

    always_comb begin
        wr_en   = i_cmd.clr_row_en || i_cmd.commit;
        wr_row  = i_cmd.clr_row_en ? i_cmd.clr_row : cur_row;
        wr_data = '0;
        if (!i_cmd.clr_row_en) begin
            wr_data = r_rd_data | (ROW_BITS'(1) << cur_bit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_bitmap[wr_row] <= wr_data;
        end
        if (i_cmd.mem_rd) begin
            r_rd_data <= r_bitmap[cur_row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size  <= SIZE_RESET;
            r_hash_select <= SEL_LENGTH;
            r_elf         <= '0;
            r_sum         <= '0;
            r_len         <= '0;
            r_coll        <= '0;
            r_used        <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_TABLE_SIZE:  r_table_size  <= i_cfg_data;
                    REG_HASH_SELECT: r_hash_select <= i_cfg_data[SEL_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.take_byte) begin
                r_elf <= elf_next;
                r_sum <= r_sum + {{(SUM_W-BYTE_W){1'b0}}, i_key_byte};
                r_len <= r_len + 1'b1;
            end else if (i_cmd.start_div) begin
                r_elf <= '0;
                r_sum <= '0;
                r_len <= '0;
            end
            if (i_cmd.clr_counts) begin
                r_coll <= '0;
                r_used <= '0;
            end else if (i_cmd.commit) begin
                if (hit) begin
                    if (r_coll != '1) r_coll <= r_coll + 1'b1;
                end else begin
                    if (r_used != '1) r_used <= r_used + 1'b1;
                end
            end
        end
    end

    // Divider and output payload: no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_div) begin
            r_quo <= hash_sel;
            r_rem <= '0;
            r_div <= eff_size;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[ELF_W-2:0], 1'b0};
            r_rem <= (rem_try >= r_div) ? rem_try - r_div : rem_try;
        end
        if (i_cmd.commit) begin
            r_bucket   <= r_rem[IDX_W-1:0];
            r_collided <= hit;
            if (hit) begin
                r_coll_out <= (r_coll != '1) ? r_coll + 1'b1 : r_coll;
                r_used_out <= r_used;
            end else begin
                r_coll_out <= r_coll;
                r_used_out <= (r_used != '1) ? r_used + 1'b1 : r_used;
            end
        end
    end

    assign o_bucket          = r_bucket;
    assign o_collided        = r_collided;
    assign o_collision_total = r_coll_out;
    assign o_buckets_used    = r_used_out;

endmodule

[rtl/hash_bucket_collision_counter.sv]
`timescale 1ns / 1ps
// Hash bucket collision counter.
// Input channel (i_in_valid / o_in_ready): one item per handshake. Mode 0
// carries a key byte, mode 1 closes the key, mode 2 clears the bitmap and
// the two counts (a key in progress is kept). Mode 3 is taken and dropped.
// Output channel (o_out_valid / i_out_ready): one item per closed key with
// the bucket, the collided flag, the collision count and buckets in use.
// Config port: i_cfg_we / i_cfg_idx / i_cfg_data, index 0 table_size,
// index 1 hash_select; write only while the block is idle.
// Sequencing: a key byte is taken in the idle state. An end of key runs
// the modulo as a restoring divider, one quotient bit per cycle over the
// 28-bit hash, then one bitmap read and one read-modify-write.
// A clear item clears the 16 bitmap rows, one row of 32 buckets per cycle.
// Reset: runs the same clearing pass with o_in_ready low.
// Stall: the result sits in an output register; bytes of the next key are
// still taken, and the next end of key waits only at its final update.

module hash_bucket_collision_counter
    import hbcc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [BYTE_W-1:0] i_key_byte,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [IDX_W-1:0]  o_bucket,
    output logic              o_collided,
    output logic [COLL_W-1:0] o_collision_total,
    output logic [USED_W-1:0] o_buckets_used,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    t_cmd cmd;

    // Sequencer: accepts items, steps the divider, runs clear passes
    hbcc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_mode      (i_mode),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // Hashes, divider, occupancy bitmap, counts and result register
    hbcc_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_key_byte        (i_key_byte),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .o_bucket          (o_bucket),
        .o_collided        (o_collided),
        .o_collision_total (o_collision_total),
        .o_buckets_used    (o_buckets_used)
    );

endmodule

[tb/sv/hash_bucket_collision_counter_tb.sv]
`timescale 1ns / 1ps

module hash_bucket_collision_counter_tb;
    import hbcc_pkg::*;

    // Codes the package leaves unnamed
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;   // taken and dropped
    localparam logic [SEL_W-1:0]  SEL_SUM    = 2'd2;
    localparam logic [SEL_W-1:0]  SEL_SPARE  = 2'd3;   // acts as byte sum

    // ELF step constants
    localparam logic [31:0] ELF_HIGH  = 32'hF000_0000;
    localparam int          ELF_FOLD  = 24;
    localparam int          ELF_STEP  = 4;
    localparam int          USED_MAX  = 1023;

    localparam int IDLE_PCT      = 38;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int RANDOM_ITEMS  = 400;

    typedef struct packed {
        logic [IDX_W-1:0]  bucket;
        logic              collided;
        logic [COLL_W-1:0] total;
        logic [USED_W-1:0] used;
    } t_bucket_report;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [MODE_W-1:0] i_mode = MODE_BYTE;
    logic [BYTE_W-1:0] i_key_byte = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [IDX_W-1:0]  o_bucket;
    logic              o_collided;
    logic [COLL_W-1:0] o_collision_total;
    logic [USED_W-1:0] o_buckets_used;
    logic              i_cfg_we = 1'b0;
    logic [CIDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]  i_cfg_data = '0;

    hash_bucket_collision_counter dut (.*);

    // Predicted block state
    logic [SIZE_W-1:0]      tbl_size = SIZE_RESET;
    logic [SEL_W-1:0]       hash_sel = SEL_LENGTH;
    logic [31:0]            elf_acc = '0;
    logic [SUM_W-1:0]       byte_sum = '0;
    logic [LEN_W-1:0]       key_len = '0;
    logic [TABLE_DEPTH-1:0] occupied = '0;
    logic [COLL_W-1:0]      coll_count = '0;
    logic [USED_W-1:0]      used_count = '0;

    t_bucket_report report_q[$];
    int             errors = 0;
    int             cycles = 0;
    bit             steady = 1'b0;   // suppresses idling on both sides

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Apply one accepted item to the predicted state
    task automatic track_item(input logic [MODE_W-1:0] mode, input logic [BYTE_W-1:0] kb);
        logic [31:0]    h;
        logic [31:0]    g;
        int             size;
        int             idx;
        t_bucket_report rep;
        case (mode)
            MODE_BYTE: begin
                h = (elf_acc << ELF_STEP) + 32'(kb);
                g = h & ELF_HIGH;
                if (g != 0) h = h ^ (g >> ELF_FOLD);
                elf_acc  = h & ~g;
                byte_sum = byte_sum + SUM_W'(kb);
                key_len  = key_len + 1'b1;
            end
            MODE_END: begin
                if (hash_sel == SEL_LENGTH) h = 32'(key_len);
                else if (hash_sel == SEL_ELF) h = elf_acc;
                else h = 32'(byte_sum);
                size = (tbl_size == 0) ? 1 : int'(tbl_size);
                if (size > TABLE_DEPTH) size = TABLE_DEPTH;
                idx = int'(h % 32'(size));
                rep.collided = occupied[idx];
                if (occupied[idx]) begin
                    if (coll_count != '1) coll_count = coll_count + 1'b1;
                end else begin
                    occupied[idx] = 1'b1;
                    if (used_count < USED_MAX) used_count = used_count + 1'b1;
                end
                elf_acc  = '0;
                byte_sum = '0;
                key_len  = '0;
                rep.bucket = IDX_W'(idx);
                rep.total  = coll_count;
                rep.used   = used_count;
                report_q.insert(report_q.size(), rep);
            end
            MODE_CLEAR: begin
                occupied   = '0;
                coll_count = '0;
                used_count = '0;
            end
            default: ;
        endcase
    endtask

    // Entered and left at a falling edge; valid stays high into the next item
    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [BYTE_W-1:0] kb);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_key_byte <= kb;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        track_item(mode, kb);
        @(negedge i_clk);
    endtask

    // Wait for every pending bucket report, then let trailing work finish
    task automatic settle_idle();
        i_in_valid <= 1'b0;
        while (report_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] size_data,
                              input logic [CFG_W-1:0] sel_data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_TABLE_SIZE;
        i_cfg_data <= size_data;
        @(negedge i_clk);
        i_cfg_idx  <= REG_HASH_SELECT;
        i_cfg_data <= sel_data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        tbl_size = size_data;
        hash_sel = sel_data[SEL_W-1:0];
        @(negedge i_clk);
    endtask

    function automatic logic [BYTE_W-1:0] pick_byte(input bit narrow);
        return narrow ? BYTE_W'(8'h61 + $urandom_range(3)) : BYTE_W'($urandom_range(255));
    endfunction

    // Key of len bytes closed by an end marker; narrow alphabet forces collisions
    task automatic send_key(input int len, input bit narrow);
        int i;
        for (i = 0; i < len; i++) send_item(MODE_BYTE, pick_byte(narrow));
        send_item(MODE_END, pick_byte(1'b0));
    endtask

    // Reset values: table 30, length hash
    task automatic test_directed();
        send_item(MODE_END, 8'hFF);               // empty key lands in bucket 0
        send_item(MODE_BYTE, 8'h00);
        send_item(MODE_BYTE, 8'hFF);
        send_item(MODE_SPARE, 8'hFF);             // ignored mid key
        send_item(MODE_BYTE, 8'hA5);
        send_item(MODE_BYTE, 8'h5A);
        send_item(MODE_END, 8'h00);
        send_item(MODE_END, 8'h00);               // bucket 0 again: collision
        send_item(MODE_SPARE, 8'h00);
        send_item(MODE_BYTE, 8'h01);
        send_item(MODE_BYTE, 8'h02);
        send_item(MODE_CLEAR, 8'h00);             // key in progress survives
        send_item(MODE_END, 8'h00);
        send_item(MODE_CLEAR, 8'hFF);
        send_item(MODE_END, 8'h00);
    endtask

    // Every selector and the size extremes, bitmap kept across size changes
    task automatic test_hash_select();
        logic [CFG_W-1:0] sizes[7];
        logic [SEL_W-1:0] sels[7];
        int               i;
        int               k;
        sizes = '{10'd0, 10'd1, 10'd512, 10'd1023, 10'd513, 10'd509, 10'd7};
        sels  = '{SEL_ELF, SEL_LENGTH, SEL_SUM, SEL_ELF, SEL_SPARE, SEL_ELF, SEL_LENGTH};
        for (i = 0; i < 7; i++) begin
            settle_idle();
            set_config(sizes[i], CFG_W'(sels[i]));
            for (k = 0; k < 3; k++) send_key($urandom_range(0, 12), 1'b0);
        end
    endtask

    // Sum hash over 512 buckets: every fourth bucket once, across all rows,
    // then one collision
    task automatic test_fill_table();
        int v;
        settle_idle();
        set_config(10'd512, CFG_W'(SEL_SUM));
        send_item(MODE_CLEAR, 8'h00);
        for (v = 0; v < TABLE_DEPTH; v += 4) begin
            if (v < 256) begin
                send_item(MODE_BYTE, 8'(v));
            end else begin
                send_item(MODE_BYTE, 8'hFF);
                send_item(MODE_BYTE, 8'(v - 255));
            end
            send_item(MODE_END, 8'h00);
        end
        send_item(MODE_END, 8'h00);
    endtask

    // Long keys under each hash, length and sum well past the table size
    task automatic test_long_keys();
        int i;
        settle_idle();
        steady = 1'b1;
        set_config(10'd61, CFG_W'(SEL_LENGTH));
        for (i = 0; i < 100; i++) send_item(MODE_BYTE, 8'hFF);
        send_item(MODE_END, 8'h00);
        settle_idle();
        set_config(10'd509, CFG_W'(SEL_SUM));
        for (i = 0; i < 100; i++) send_item(MODE_BYTE, 8'hFF);
        send_item(MODE_END, 8'h00);
        settle_idle();
        set_config(10'd509, CFG_W'(SEL_ELF));
        send_key(150, 1'b0);
        steady = 1'b0;
    endtask

    task automatic test_random();
        int               counted;
        int               keys;
        int               len;
        int               r;
        logic [CFG_W-1:0] size_data;
        counted = 0;
        keys = 0;
        while (counted < RANDOM_ITEMS) begin
            steady = (counted >= 120 && counted < 320);
            if (keys % 25 == 24) begin
                // pause until every report is back, then retune the table
                settle_idle();
                case ($urandom_range(5))
                    0: size_data = 10'd0;
                    1: size_data = 10'd1;
                    2: size_data = 10'd512;
                    3: size_data = 10'd1023;
                    4: size_data = CFG_W'($urandom_range(2, 16));
                    default: size_data = CFG_W'($urandom_range(17, 1023));
                endcase
                set_config(size_data, CFG_W'($urandom_range(1023)));
                keys++;
            end
            r = $urandom_range(99);
            if (r < 80) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
                send_key(len, $urandom_range(3) == 0);
                counted += len + 1;
                keys++;
            end else if (r < 88) begin
                send_item(MODE_CLEAR, pick_byte(1'b0));
                counted++;
            end else if (r < 93) begin
                send_item(MODE_SPARE, pick_byte(1'b0));
            end else begin
                // unterminated bytes run into the next key
                len = $urandom_range(1, 5);
                repeat (len) send_item(MODE_BYTE, pick_byte(1'b0));
                counted += len;
            end
        end
        steady = 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_bucket_report want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (report_q.size() == 0) begin
                $error("unexpected result: bucket %0d", o_bucket);
                errors++;
            end else begin
                want = report_q.pop_front();
                if (o_bucket !== want.bucket) begin
                    $error("bucket: expected %0d, got %0d", want.bucket, o_bucket);
                    errors++;
                end
                if (o_collided !== want.collided) begin
                    $error("collided: expected %0d, got %0d", want.collided, o_collided);
                    errors++;
                end
                if (o_collision_total !== want.total) begin
                    $error("collision_total: expected %0d, got %0d",
                           want.total, o_collision_total);
                    errors++;
                end
                if (o_buckets_used !== want.used) begin
                    $error("buckets_used: expected %0d, got %0d", want.used, o_buckets_used);
                    errors++;
                end
            end
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_hash_select();
        test_fill_table();
        test_random();
        test_long_keys();
        settle_idle();
        if (errors == 0 && report_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/hbcc_pkg.sv
rtl/hbcc_ctrl.sv
rtl/hbcc_datapath.sv
rtl/hash_bucket_collision_counter.sv
tb/sv/hash_bucket_collision_counter_tb.sv
